// ===== rtl/lob_pkg.sv =====
// Shared types and constants of the limit order book core.
// Depends on nothing; lob_ffs and the core import it, while lob_ram does not.
`timescale 1ns / 1ps
`default_nettype none
package lob_pkg;
  localparam int IdW       = 12;
  localparam int PriceW    = 8;
  localparam int LvlW      = PriceW + 1;
  localparam int BitW      = 4;
  localparam int WordW     = 16;
  localparam int HiW       = PriceW - BitW;
  localparam int RowW      = IdW - BitW;
  localparam int IdSpace   = 1 << IdW;
  localparam int LiveRows  = 1 << RowW;
  localparam int Levels    = 1 << LvlW;
  localparam int OccRows   = 1 << (LvlW - BitW);
  localparam int InfoW     = 1 + PriceW;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_POP    = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_LIVE_RD, S_LIVE_CHK, S_ADD_RD, S_ADD_DO,
    S_POP_SUM, S_POP_WORD, S_POP_HD, S_POP_ID, S_UNL_RD, S_UNL_DO,
    S_B_SUM, S_B_WORD, S_B_HEAD, S_A_SUM, S_A_WORD, S_A_HEAD, S_OUT
  } state_e;

  typedef struct packed {
    logic            found;
    logic [BitW-1:0] idx;
  } ffs_t;
endpackage
`default_nettype wire

// ===== rtl/lob_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Old data is returned when a location is read and written in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module lob_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/lob_ffs.sv =====
// Shared find-first unit: highest or lowest set bit of one bitmap word.
// Depends on lob_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lob_ffs (
  input  wire logic [lob_pkg::WordW-1:0] vec_i,
  input  wire logic                      high_i,
  output lob_pkg::ffs_t                  res_o
);
  import lob_pkg::*;

  always_comb begin
    res_o = '0;
    for (int i = 0; i < WordW; i++) begin
      if (high_i) begin
        if (vec_i[i]) begin
          res_o.found = 1'b1;
          res_o.idx   = BitW'(i);
        end
      end else if (vec_i[WordW-1-i]) begin
        res_o.found = 1'b1;
        res_o.idx   = BitW'(WordW-1-i);
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/limit_order_book_core.sv =====
// Limit order book core: a sequencer over the order, link and level RAMs.
// Each word runs its add, cancel or pop steps, if any, then the best-bid and best-ask lookups;
// each empty side skips its word and head steps and a rejected add or cancel skips its two update steps.
// Throughput: one word at a time; most steps wait for a registered RAM read,
// the find-first unit is shared, and the next word is taken once back in idle.
// Reset: asynchronous, active low; row valid bits and level summaries clear at
// once, so no clearing pass is needed and the first word is accepted at once.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_book_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 op_i,
  input  wire logic                       side_i,
  input  wire logic [lob_pkg::IdW-1:0]    ord_id_i,
  input  wire logic [lob_pkg::PriceW-1:0] price_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      status_o,
  output logic [lob_pkg::IdW-1:0]         removed_id_o,
  output logic [lob_pkg::PriceW-1:0]      removed_price_o,
  output logic                            bid_valid_o,
  output logic [lob_pkg::IdW-1:0]         bid_ord_id_o,
  output logic [lob_pkg::PriceW-1:0]      bid_price_o,
  output logic                            ask_valid_o,
  output logic [lob_pkg::IdW-1:0]         ask_ord_id_o,
  output logic [lob_pkg::PriceW-1:0]      ask_price_o
);
  import lob_pkg::*;

  state_e state_q, state_d;
  op_e op_q, op_d;
  logic side_q, side_d;
  logic [IdW-1:0] id_q, id_d;
  logic [PriceW-1:0] price_q, price_d;
  logic [LvlW-1:0] lv_q, lv_d;
  logic [HiW-1:0] hi_q, hi_d;
  status_e st_q, st_d;
  logic [IdW-1:0] rid_q, rid_d, bid_q, bid_d, aid_q, aid_d;
  logic [PriceW-1:0] rpr_q, rpr_d, bp_q, bp_d, ap_q, ap_d;
  logic bv_q, bv_d, av_q, av_d;
  logic [LiveRows-1:0] rowv_q, rowv_d;
  logic [1:0][WordW-1:0] sum_q, sum_d;
  logic out_vld_q, out_vld_d, out_load;

  logic live_we, info_we, nxt_we, prv_we, head_we, tail_we, occ_we;
  logic [RowW-1:0] live_wa;
  logic [WordW-1:0] live_wd, live_rd, occ_wd, occ_rd;
  logic [IdW-1:0] info_wa, nxt_wa, prv_wa, nxt_wd, prv_wd, nxt_rd, prv_rd;
  logic [InfoW-1:0] info_wd, info_rd;
  logic [LvlW-1:0] head_wa, tail_wa, head_ra;
  logic [IdW-1:0] head_wd, tail_wd, head_rd, tail_rd;
  logic [LvlW-BitW-1:0] occ_wa, occ_ra;

  logic [WordW-1:0] ffs_vec;
  logic ffs_high;
  ffs_t ffs_res;

  logic [WordW-1:0] live_word, occ_old, id_mask, lv_mask, occ_new;
  logic live_bit, lv_occ;

  lob_ram #(.W(WordW), .D(LiveRows)) u_live (
    .clk_i, .we_i(live_we), .waddr_i(live_wa), .wdata_i(live_wd),
    .raddr_i(id_q[IdW-1:BitW]), .rdata_o(live_rd));
  lob_ram #(.W(InfoW), .D(IdSpace)) u_info (
    .clk_i, .we_i(info_we), .waddr_i(info_wa), .wdata_i(info_wd),
    .raddr_i(id_q), .rdata_o(info_rd));
  lob_ram #(.W(IdW), .D(IdSpace)) u_nxt (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_wa), .wdata_i(nxt_wd),
    .raddr_i(id_q), .rdata_o(nxt_rd));
  lob_ram #(.W(IdW), .D(IdSpace)) u_prv (
    .clk_i, .we_i(prv_we), .waddr_i(prv_wa), .wdata_i(prv_wd),
    .raddr_i(id_q), .rdata_o(prv_rd));
  lob_ram #(.W(IdW), .D(Levels)) u_head (
    .clk_i, .we_i(head_we), .waddr_i(head_wa), .wdata_i(head_wd),
    .raddr_i(head_ra), .rdata_o(head_rd));
  lob_ram #(.W(IdW), .D(Levels)) u_tail (
    .clk_i, .we_i(tail_we), .waddr_i(tail_wa), .wdata_i(tail_wd),
    .raddr_i(lv_q), .rdata_o(tail_rd));
  lob_ram #(.W(WordW), .D(OccRows)) u_occ (
    .clk_i, .we_i(occ_we), .waddr_i(occ_wa), .wdata_i(occ_wd),
    .raddr_i(occ_ra), .rdata_o(occ_rd));

  lob_ffs u_ffs (.vec_i(ffs_vec), .high_i(ffs_high), .res_o(ffs_res));

  assign id_mask   = WordW'(1) << id_q[BitW-1:0];
  assign lv_mask   = WordW'(1) << lv_q[BitW-1:0];
  assign live_word = rowv_q[id_q[IdW-1:BitW]] ? live_rd : '0;
  assign live_bit  = |(live_word & id_mask);
  assign occ_old   = sum_q[lv_q[LvlW-1]][lv_q[PriceW-1:BitW]] ? occ_rd : '0;
  assign lv_occ    = |(occ_old & lv_mask);
  assign occ_new   = occ_old & ~lv_mask;
  assign out_load  = (state_q == S_OUT) && (!out_vld_q || !out_stall_i);
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    ffs_vec  = occ_rd;
    ffs_high = 1'b1;
    head_ra  = lv_q;
    occ_ra   = lv_q[LvlW-1:BitW];
    unique case (state_q)
      S_POP_SUM: begin
        ffs_vec  = sum_q[side_q];
        ffs_high = !side_q;
        occ_ra   = {side_q, ffs_res.idx};
      end
      S_POP_WORD: ffs_high = !side_q;
      S_B_SUM: begin
        ffs_vec = sum_q[0];
        occ_ra  = {1'b0, ffs_res.idx};
      end
      S_B_WORD: head_ra = {1'b0, hi_q, ffs_res.idx};
      S_A_SUM: begin
        ffs_vec  = sum_q[1];
        ffs_high = 1'b0;
        occ_ra   = {1'b1, ffs_res.idx};
      end
      S_A_WORD: begin
        ffs_high = 1'b0;
        head_ra  = {1'b1, hi_q, ffs_res.idx};
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(op_i))
            OP_ADD, OP_CANCEL: state_d = S_LIVE_RD;
            OP_POP:            state_d = S_POP_SUM;
            OP_QUERY:          state_d = S_B_SUM;
          endcase
        end
      end
      S_LIVE_RD: state_d = S_LIVE_CHK;
      S_LIVE_CHK: begin
        if (op_q == OP_ADD) begin
          state_d = live_bit ? S_B_SUM : S_ADD_RD;
        end else begin
          state_d = live_bit ? S_UNL_RD : S_B_SUM;
        end
      end
      S_ADD_RD:   state_d = S_ADD_DO;
      S_ADD_DO:   state_d = S_B_SUM;
      S_POP_SUM:  state_d = ffs_res.found ? S_POP_WORD : S_B_SUM;
      S_POP_WORD: state_d = S_POP_HD;
      S_POP_HD:   state_d = S_POP_ID;
      S_POP_ID:   state_d = S_UNL_RD;
      S_UNL_RD:   state_d = S_UNL_DO;
      S_UNL_DO:   state_d = S_B_SUM;
      S_B_SUM:    state_d = ffs_res.found ? S_B_WORD : S_A_SUM;
      S_B_WORD:   state_d = S_B_HEAD;
      S_B_HEAD:   state_d = S_A_SUM;
      S_A_SUM:    state_d = ffs_res.found ? S_A_WORD : S_OUT;
      S_A_WORD:   state_d = S_A_HEAD;
      S_A_HEAD:   state_d = S_OUT;
      S_OUT:      state_d = out_load ? S_IDLE : S_OUT;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_d = op_q; side_d = side_q; id_d = id_q; price_d = price_q;
    lv_d = lv_q; hi_d = hi_q; st_d = st_q; rid_d = rid_q; rpr_d = rpr_q;
    bv_d = bv_q; bid_d = bid_q; bp_d = bp_q; av_d = av_q; aid_d = aid_q; ap_d = ap_q;
    rowv_d = rowv_q; sum_d = sum_q;
    live_we = 1'b0; live_wa = id_q[IdW-1:BitW]; live_wd = live_word | id_mask;
    info_we = 1'b0; info_wa = id_q; info_wd = {side_q, price_q};
    nxt_we = 1'b0; nxt_wa = tail_rd; nxt_wd = id_q;
    prv_we = 1'b0; prv_wa = id_q; prv_wd = tail_rd;
    head_we = 1'b0; head_wa = lv_q; head_wd = id_q;
    tail_we = 1'b0; tail_wa = lv_q; tail_wd = id_q;
    occ_we = 1'b0; occ_wa = lv_q[LvlW-1:BitW]; occ_wd = occ_old | lv_mask;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = op_e'(op_i); side_d = side_i; id_d = ord_id_i; price_d = price_i;
          st_d = ST_OK; rid_d = '0; rpr_d = '0;
          bv_d = 1'b0; bid_d = '0; bp_d = '0; av_d = 1'b0; aid_d = '0; ap_d = '0;
        end
      end
      S_LIVE_CHK: begin
        if (op_q == OP_ADD) begin
          if (live_bit) begin
            st_d = ST_DUP;
          end else begin
            live_we = 1'b1;
            info_we = 1'b1;
            rowv_d[id_q[IdW-1:BitW]] = 1'b1;
            lv_d = {side_q, price_q};
          end
        end else if (!live_bit) begin
          st_d = ST_UNKNOWN;
        end else begin
          rid_d = id_q;
          rpr_d = info_rd[PriceW-1:0];
          lv_d  = info_rd;
        end
      end
      S_ADD_DO: begin
        if (lv_occ) begin
          nxt_we = 1'b1;
          prv_we = 1'b1;
          tail_we = 1'b1;
        end else begin
          head_we = 1'b1;
          tail_we = 1'b1;
          occ_we = 1'b1;
          sum_d[lv_q[LvlW-1]][lv_q[PriceW-1:BitW]] = 1'b1;
        end
      end
      S_POP_SUM: begin
        if (!ffs_res.found) begin
          st_d = ST_EMPTY;
        end
        hi_d = ffs_res.idx;
      end
      S_POP_WORD: lv_d = {side_q, hi_q, ffs_res.idx};
      S_POP_ID: begin
        id_d  = head_rd;
        rid_d = head_rd;
        rpr_d = lv_q[PriceW-1:0];
      end
      S_UNL_DO: begin
        live_we = 1'b1;
        live_wd = live_rd & ~id_mask;
        if (head_rd == id_q && tail_rd == id_q) begin
          occ_we = 1'b1;
          occ_wd = occ_new;
          sum_d[lv_q[LvlW-1]][lv_q[PriceW-1:BitW]] = |occ_new;
        end else if (head_rd == id_q) begin
          head_we = 1'b1;
          head_wd = nxt_rd;
        end else if (tail_rd == id_q) begin
          tail_we = 1'b1;
          tail_wd = prv_rd;
        end else begin
          prv_we = 1'b1;
          prv_wa = nxt_rd;
          prv_wd = prv_rd;
          nxt_we = 1'b1;
          nxt_wa = prv_rd;
          nxt_wd = nxt_rd;
        end
      end
      S_B_SUM:  hi_d = ffs_res.idx;
      S_B_WORD: begin
        bv_d = 1'b1;
        bp_d = {hi_q, ffs_res.idx};
      end
      S_B_HEAD: bid_d = head_rd;
      S_A_SUM:  hi_d = ffs_res.idx;
      S_A_WORD: begin
        av_d = 1'b1;
        ap_d = {hi_q, ffs_res.idx};
      end
      S_A_HEAD: aid_d = head_rd;
      default: ;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rowv_q    <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rowv_q    <= rowv_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; side_q <= side_d; id_q <= id_d; price_q <= price_d;
    lv_q <= lv_d; hi_q <= hi_d; st_q <= st_d; rid_q <= rid_d; rpr_q <= rpr_d;
    bv_q <= bv_d; bid_q <= bid_d; bp_q <= bp_d;
    av_q <= av_d; aid_q <= aid_d; ap_q <= ap_d;
    if (out_load) begin
      status_o        <= st_q;
      removed_id_o    <= rid_q;
      removed_price_o <= rpr_q;
      bid_valid_o     <= bv_q;
      bid_ord_id_o    <= bid_q;
      bid_price_o     <= bp_q;
      ask_valid_o     <= av_q;
      ask_ord_id_o    <= aid_q;
      ask_price_o     <= ap_q;
    end
  end

  assign out_valid_o = out_vld_q;
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for limit_order_book_core: random and directed add, cancel, pop and query words.
// A behavioral order book predicts each result word; depends on rtl/lob_pkg.sv and the core.
`timescale 1ns / 1ps
module tb;
  import lob_pkg::*;

  typedef struct packed {
    logic [1:0]        op;
    logic              side;
    logic [IdW-1:0]    id;
    logic [PriceW-1:0] price;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    rid;
    logic [PriceW-1:0] rprice;
    logic              bv;
    logic [IdW-1:0]    bid;
    logic [PriceW-1:0] bp;
    logic              av;
    logic [IdW-1:0]    aid;
    logic [PriceW-1:0] ap;
  } book_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic side = 1'b0;
  logic [IdW-1:0] cmd_id = '0;
  logic [PriceW-1:0] price = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  book_t got;

  cmd_t pending_cmds[$];
  book_t expected_books[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_off = 0;
  int gap = 0;
  int burst = 0;
  bit stim_done = 1'b0;

  // Shadow order book: per-side price levels hold FIFOs of order ids.
  bit live[IdSpace];
  bit oside[IdSpace];
  logic [PriceW-1:0] oprice[IdSpace];
  int fifo[Levels][$];

  limit_order_book_core u_dut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .side_i(side), .ord_id_i(cmd_id), .price_i(price),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(got.status), .removed_id_o(got.rid), .removed_price_o(got.rprice),
    .bid_valid_o(got.bv), .bid_ord_id_o(got.bid), .bid_price_o(got.bp),
    .ask_valid_o(got.av), .ask_ord_id_o(got.aid), .ask_price_o(got.ap)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int best_price(bit s);
    if (!s) begin
      for (int p = 255; p >= 0; p--) if (fifo[p].size() != 0) return p;
    end else begin
      for (int p = 0; p < 256; p++) if (fifo[256 + p].size() != 0) return p;
    end
    return -1;
  endfunction

  function automatic void unlink(int id);
    int lv;
    lv = oside[id] * 256 + oprice[id];
    foreach (fifo[lv][k]) begin
      if (fifo[lv][k] == id) begin
        fifo[lv].delete(k);
        break;
      end
    end
    live[id] = 1'b0;
  endfunction

  function automatic book_t apply_cmd(cmd_t c);
    book_t r;
    int p;
    int lv;
    r = '0;
    case (op_e'(c.op))
      OP_ADD: begin
        if (live[c.id]) r.status = ST_DUP;
        else begin
          live[c.id] = 1'b1;
          oside[c.id] = c.side;
          oprice[c.id] = c.price;
          lv = c.side * 256 + c.price;
          fifo[lv].insert(fifo[lv].size(), c.id);
        end
      end
      OP_CANCEL: begin
        if (!live[c.id]) r.status = ST_UNKNOWN;
        else begin
          r.rid = c.id;
          r.rprice = oprice[c.id];
          unlink(c.id);
        end
      end
      OP_POP: begin
        p = best_price(c.side);
        if (p < 0) r.status = ST_EMPTY;
        else begin
          r.rid = fifo[c.side * 256 + p][0];
          r.rprice = p;
          unlink(r.rid);
        end
      end
      default: ;
    endcase
    p = best_price(1'b0);
    if (p >= 0) begin
      r.bv = 1'b1;
      r.bp = p;
      r.bid = fifo[p][0];
    end
    p = best_price(1'b1);
    if (p >= 0) begin
      r.av = 1'b1;
      r.ap = p;
      r.aid = fifo[256 + p][0];
    end
    return r;
  endfunction

  function automatic void push_cmd(logic [1:0] o, bit s, int id, int pr);
    cmd_t c;
    c.op = o;
    c.side = s;
    c.id = id;
    c.price = pr;
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // Ids come mostly from a small pool so cancels and duplicates hit live orders.
  initial begin
    int id;
    push_cmd(OP_POP, 0, 0, 0);
    push_cmd(OP_POP, 1, 0, 0);
    push_cmd(OP_QUERY, 0, 0, 0);
    push_cmd(OP_CANCEL, 0, 4095, 0);
    push_cmd(OP_ADD, 0, 0, 0);
    push_cmd(OP_ADD, 0, 4095, 255);
    push_cmd(OP_ADD, 1, 4094, 255);
    push_cmd(OP_ADD, 1, 1, 0);
    push_cmd(OP_ADD, 1, 2, 0);
    push_cmd(OP_ADD, 0, 3, 255);
    push_cmd(OP_ADD, 0, 0, 7);
    push_cmd(OP_ADD, 0, 5, 255);
    push_cmd(OP_CANCEL, 1, 3, 0);
    push_cmd(OP_CANCEL, 0, 1, 0);
    push_cmd(OP_POP, 0, 0, 0);
    push_cmd(OP_POP, 1, 0, 0);
    push_cmd(OP_QUERY, 1, 4095, 255);
    push_cmd(OP_POP, 0, 0, 0);
    push_cmd(OP_POP, 0, 0, 0);
    push_cmd(OP_POP, 1, 0, 0);
    push_cmd(OP_POP, 1, 0, 0);
    for (int i = 0; i < 1000; i++) begin
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
      push_cmd($urandom_range(0, 9) < 4 ? OP_ADD : $urandom_range(1, 3), $urandom_range(0, 1),
               id, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(120, 135));
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst <= 0;
      gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_books.insert(expected_books.size(), apply_cmd({op, side, cmd_id, price}));
      end
      if (!in_valid || !in_stall) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          {op, side, cmd_id, price} <= pending_cmds[0];
          pending_cmds.delete(0);
          in_valid <= 1'b1;
          if (burst == 0) begin
            burst <= $urandom_range(1, 30);
            gap <= $urandom_range(0, 1) ? 0 : $urandom_range(1, 25);
          end else begin
            burst <= burst - 1;
          end
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_off <= 0;
    end else begin
      cycles <= cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_books.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result word %h", got);
        end else if (got !== expected_books[0]) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %h actual %h",
                                         expected_books[0], got);
          expected_books.delete(0);
        end else begin
          expected_books.delete(0);
        end
      end
      if (cycles == 3000) hold_off <= 600;
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (cycles % 97 > 60) ? ($urandom_range(0, 2) != 0) : 1'b0;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (!(stim_done && expected_books.size() == 0 && !in_valid) && cycles < 400000)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (cycles >= 400000 || expected_books.size() != 0) begin
      $display("*** FAILED ***");
    end else if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
